// ----- src/dcps_pkg.sv -----
`default_nettype none
package dcps_pkg;

  localparam int BODY_SLOTS   = 8;
  localparam int DISC_RADIUS  = 4;
  localparam int FIELD_WIDTH  = 320;
  localparam int FIELD_HEIGHT = 240;

  localparam int ADDR_W = $clog2(BODY_SLOTS);
  localparam int CNT_W  = $clog2(BODY_SLOTS + 1);

  // geometry in 1/64 pixel, MIN_D2 in its square, OV_BASE in 1/4096 pixel
  localparam logic [23:0] R_FIX   = 24'(DISC_RADIUS * 64);
  localparam logic [15:0] R_POS   = 16'(DISC_RADIUS * 64);
  localparam logic [23:0] X_HIGH  = 24'(FIELD_WIDTH * 64);
  localparam logic [23:0] Y_HIGH  = 24'(FIELD_HEIGHT * 64);
  localparam logic [15:0] X_CLAMP = 16'((FIELD_WIDTH - DISC_RADIUS) * 64);
  localparam logic [15:0] Y_CLAMP = 16'((FIELD_HEIGHT - DISC_RADIUS) * 64);
  localparam logic [33:0] MIN_D2  = 34'((2 * DISC_RADIUS * 64) * (2 * DISC_RADIUS * 64));
  localparam logic [18:0] OV_BASE = 19'(2 * DISC_RADIUS * 4096);

  localparam logic signed [15:0] VEL_ONE  = 16'sd1024;
  localparam logic signed [15:0] VEL_SLOW = 16'sd1536;

  localparam int LEVEL_STEP = 20;
  localparam int LEVEL_MAX  = 255;
  localparam int LEVEL_SAT  = LEVEL_MAX / LEVEL_STEP + 1;

  localparam int SQ_IN_W  = 38;
  localparam int SQ_OUT_W = 19;
  localparam int DIV_W    = 32;
  localparam int DVS_W    = 19;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_SPAWN = 3'd1;
  localparam logic [2:0] MODE_KILL  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic [2:0] KIND_WALL    = 3'd0;
  localparam logic [2:0] KIND_COLL    = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_REPORT  = 3'd3;
  localparam logic [2:0] KIND_NOTHING = 3'd4;

  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } body_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] level;
    logic [2:0] slot;
    logic [9:0] px;
    logic [9:0] py;
    logic       alive;
    logic [3:0] count;
    logic       last;
  } res_t;

  function automatic res_t make_res(input logic [2:0] kind, input logic [7:0] level,
                                    input logic [2:0] slot, input logic [9:0] px,
                                    input logic [9:0] py, input logic alive,
                                    input logic [3:0] count, input logic last);
    res_t r;
    r.kind  = kind;
    r.level = level;
    r.slot  = slot;
    r.px    = px;
    r.py    = py;
    r.alive = alive;
    r.count = count;
    r.last  = last;
    return r;
  endfunction

  function automatic logic [15:0] sat_pos(input logic signed [23:0] v);
    logic [15:0] r;
    if (v < 0) r = 16'd0;
    else if (v > 24'sd65535) r = 16'hFFFF;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_vel(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v < -24'sd32768) r = -16'sd32768;
    else if (v > 24'sd32767) r = 16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] abs_vel(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == -16'sd32768) r = 16'sd32767;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

  // shift right with halves rounded away from zero
  function automatic logic signed [23:0] shr_round(input logic signed [47:0] v,
                                                   input int s);
    logic [47:0] m;
    logic [47:0] q;
    m = v[47] ? 48'(-v) : 48'(v);
    q = (m + (48'd1 << (s - 1))) >> s;
    if (v[47]) q = -q;
    return q[23:0];
  endfunction

  function automatic logic [7:0] level_of(input logic [9:0] whole);
    logic [7:0] r;
    if (whole >= 10'(LEVEL_SAT)) r = 8'(LEVEL_MAX);
    else r = 8'(whole * 10'(LEVEL_STEP));
    return r;
  endfunction

  function automatic logic signed [15:0] spawn_vel(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > -VEL_ONE && v < VEL_ONE) r = (v >= 0) ? VEL_SLOW : -VEL_SLOW;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/dcps_body_ram.sv -----
`default_nettype none
module dcps_body_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [dcps_pkg::ADDR_W-1:0] waddr,
  input  wire dcps_pkg::body_t             wdata,
  input  wire logic [dcps_pkg::ADDR_W-1:0] raddr,
  output dcps_pkg::body_t                  rdata
);
  import dcps_pkg::*;

  body_t mem [BODY_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/dcps_isqrt.sv -----
`default_nettype none
module dcps_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dcps_pkg::SQ_IN_W-1:0]  operand,
  output logic                               done,
  output logic [dcps_pkg::SQ_OUT_W-1:0]      root
);
  import dcps_pkg::*;

  logic [SQ_IN_W-1:0]  opr;
  logic [SQ_OUT_W+1:0] rem;
  logic [4:0]          cnt;
  logic                run;
  logic [SQ_OUT_W+3:0] rem_t;
  logic [SQ_OUT_W+3:0] trial;
  logic                ge;

  // one root bit per cycle, restoring
  assign rem_t = {rem, opr[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opr  <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= 5'(SQ_OUT_W);
        run  <= 1'b1;
      end else if (run) begin
        rem  <= ge ? (SQ_OUT_W+2)'(rem_t - trial) : (SQ_OUT_W+2)'(rem_t);
        root <= {root[SQ_OUT_W-2:0], ge};
        opr  <= {opr[SQ_IN_W-3:0], 2'b00};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/dcps_div.sv -----
`default_nettype none
module dcps_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dcps_pkg::DIV_W-1:0]  dividend,
  input  wire logic [dcps_pkg::DVS_W-1:0]  divisor,
  output logic                             done,
  output logic [dcps_pkg::DIV_W-1:0]       quotient
);
  import dcps_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [5:0]       cnt;
  logic             run;
  logic [DVS_W:0]   rem_t;
  logic             ge;

  // restoring divide, one quotient bit per cycle
  assign rem_t = {rem, quotient[DIV_W-1]};
  assign ge    = rem_t >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        cnt      <= 6'(DIV_W);
        run      <= 1'b1;
      end else if (run) begin
        rem      <= ge ? DVS_W'(rem_t - {1'b0, divisor}) : DVS_W'(rem_t);
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/disc_collision_physics_step_unit.sv -----
`default_nettype none
// spawn, clear and nothing-done answer in the cycle after the accepted beat,
//   read and kill go through S_RD_WAIT and S_RD_REP, each with a single result beat
// tick: free slots are skipped, each alive disc is moved, tested at the walls and then
//   paired with each later alive disc; a wall hit runs the 19-step square root, an
//   overlapping pair it and two 32-step divides, and a result stall holds the walk;
// one item at a time, the next item is taken once the last result beat is taken;
//   reset (rst, synchronous): all slots free, count zero, the body ram is not cleared
module disc_collision_physics_step_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [2:0]         mode,
  input  wire logic [2:0]         body_index,
  input  wire logic [15:0]        spawn_x,
  input  wire logic [15:0]        spawn_y,
  input  wire logic signed [15:0] spawn_vx,
  input  wire logic signed [15:0] spawn_vy,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [2:0]              kind,
  output logic [7:0]              impact_level,
  output logic [2:0]              slot,
  output logic [9:0]              pixel_x,
  output logic [9:0]              pixel_y,
  output logic                    is_alive,
  output logic [3:0]              body_count,
  output logic                    last
);
  import dcps_pkg::*;

  // sequencer states
  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_OUT     = 6'd1;
  localparam logic [5:0] S_RD_WAIT = 6'd2;
  localparam logic [5:0] S_RD_REP  = 6'd3;
  localparam logic [5:0] S_T_NEXT  = 6'd4;
  localparam logic [5:0] S_T_WAIT  = 6'd5;
  localparam logic [5:0] S_T_LOAD  = 6'd6;
  localparam logic [5:0] S_T_WALL  = 6'd7;
  localparam logic [5:0] S_SPD0    = 6'd8;
  localparam logic [5:0] S_SPD1    = 6'd9;
  localparam logic [5:0] S_SPD2    = 6'd10;
  localparam logic [5:0] S_SPD3    = 6'd11;
  localparam logic [5:0] S_P_NEXT  = 6'd12;
  localparam logic [5:0] S_P_WAIT  = 6'd13;
  localparam logic [5:0] S_P_LOAD  = 6'd14;
  localparam logic [5:0] S_P_D2A   = 6'd15;
  localparam logic [5:0] S_P_D2B   = 6'd16;
  localparam logic [5:0] S_P_CHK   = 6'd17;
  localparam logic [5:0] S_P_SQ    = 6'd18;
  localparam logic [5:0] S_P_DXS   = 6'd19;
  localparam logic [5:0] S_P_DX    = 6'd20;
  localparam logic [5:0] S_P_DYS   = 6'd21;
  localparam logic [5:0] S_P_DY    = 6'd22;
  localparam logic [5:0] S_P_SX    = 6'd23;
  localparam logic [5:0] S_P_SX2   = 6'd24;
  localparam logic [5:0] S_P_SY2   = 6'd25;
  localparam logic [5:0] S_P_PUSH  = 6'd26;
  localparam logic [5:0] S_P_DOT1  = 6'd27;
  localparam logic [5:0] S_P_DOT2  = 6'd28;
  localparam logic [5:0] S_P_DOT3  = 6'd29;
  localparam logic [5:0] S_P_DOT4  = 6'd30;
  localparam logic [5:0] S_P_CX    = 6'd31;
  localparam logic [5:0] S_P_CY    = 6'd32;
  localparam logic [5:0] S_P_SKIP  = 6'd33;
  localparam logic [5:0] S_T_WB    = 6'd34;

  logic [5:0] state;
  logic [5:0] ret;          // where to go once the result beat is taken
  res_t       res;

  // slot bookkeeping, kept in flops so free/alive search is immediate
  logic [BODY_SLOTS-1:0] alive;
  logic [3:0]            total;

  // tick walk: cur is the moving disc i, oth the partner j
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] oth;
  logic [2:0]       wall;

  // disc i lives in these registers for the whole pair walk, written back at the end
  logic [15:0]        xi, yi;
  logic signed [15:0] vxi, vyi;
  logic [15:0]        xj, yj;
  logic signed [15:0] vxj, vyj;

  logic signed [16:0] dx, dy;
  logic [33:0]        acc;
  logic [18:0]        d;
  logic signed [19:0] nx, ny;
  logic signed [41:0] pr;
  logic signed [42:0] acc2;
  logic signed [23:0] sx, sy, cx;
  logic signed [19:0] dotv;

  logic [ADDR_W-1:0] rep_slot;
  logic              rep_alive;
  logic [3:0]        rep_count;

  // body ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  body_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  body_t             ram_rdata;

  // shared arithmetic
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] mul_p;
  logic               sq_start, sq_done;
  logic [SQ_IN_W-1:0] sq_op;
  logic [SQ_OUT_W-1:0] sq_root;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_num, div_q;
  logic [18:0]        ov;
  logic [16:0]        dx_mag, dy_mag;
  logic signed [23:0] cy;
  logic signed [15:0] nvxi, nvyi, nvxj, nvyj;

  logic              accept;
  logic              has_free, has_alive;
  logic [ADDR_W-1:0] free_slot, high_slot;
  logic              wall_hit;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);

  assign kind         = res.kind;
  assign impact_level = res.level;
  assign slot         = res.slot;
  assign pixel_x      = res.px;
  assign pixel_y      = res.py;
  assign is_alive     = res.alive;
  assign body_count   = res.count;
  assign last         = res.last;

  // lowest free slot for spawn, highest alive slot for kill
  always_comb begin
    has_free  = 1'b0;
    free_slot = '0;
    for (int k = BODY_SLOTS - 1; k >= 0; k--) begin
      if (!alive[k]) begin
        has_free  = 1'b1;
        free_slot = ADDR_W'(k);
      end
    end
    has_alive = 1'b0;
    high_slot = '0;
    for (int k = 0; k < BODY_SLOTS; k++) begin
      if (alive[k]) begin
        has_alive = 1'b1;
        high_slot = ADDR_W'(k);
      end
    end
  end

  // wall tests in order right, left, bottom, top
  always_comb begin
    case (wall)
      3'd0:    wall_hit = ({8'd0, xi} + R_FIX) >= X_HIGH;
      3'd1:    wall_hit = {8'd0, xi} <= R_FIX;
      3'd2:    wall_hit = ({8'd0, yi} + R_FIX) >= Y_HIGH;
      3'd3:    wall_hit = {8'd0, yi} <= R_FIX;
      default: wall_hit = 1'b0;
    endcase
  end

  assign ov     = 19'((OV_BASE - d) >> 1);
  assign dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_mag = dy[16] ? 17'(-dy) : 17'(dy);

  // velocity exchange applied in S_P_CY
  assign cy   = shr_round(48'(pr), 14);
  assign nvxi = sat_vel(24'(vxi) - cx);
  assign nvyi = sat_vel(24'(vyi) - cy);
  assign nvxj = sat_vel(24'(vxj) + cx);
  assign nvyj = sat_vel(24'(vyj) + cy);

  // one multiplier, operands picked by the sequencer step
  always_comb begin
    case (state)
      S_SPD0:   begin mul_a = 21'(vxi); mul_b = 21'(vxi); end
      S_SPD1:   begin mul_a = 21'(vyi); mul_b = 21'(vyi); end
      S_P_D2A:  begin mul_a = 21'(dx); mul_b = 21'(dx); end
      S_P_D2B:  begin mul_a = 21'(dy); mul_b = 21'(dy); end
      S_P_SX:   begin mul_a = 21'(nx); mul_b = $signed({2'b00, ov}); end
      S_P_SX2:  begin mul_a = 21'(ny); mul_b = $signed({2'b00, ov}); end
      S_P_DOT1: begin mul_a = 21'(17'(vxi) - 17'(vxj)); mul_b = 21'(nx); end
      S_P_DOT2: begin mul_a = 21'(17'(vyi) - 17'(vyj)); mul_b = 21'(ny); end
      S_P_DOT4: begin mul_a = 21'(dotv); mul_b = 21'(nx); end
      S_P_CX:   begin mul_a = 21'(dotv); mul_b = 21'(ny); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // square root: speed of a disc, or pair distance scaled to 1/4096 pixel
  assign sq_start = (state == S_SPD2) ||
                    (state == S_P_CHK && acc != 34'd0 && acc < MIN_D2);
  assign sq_op    = (state == S_SPD2) ? {4'd0, acc} : {acc[25:0], 12'd0};

  // normal components: |d*| * 2^20 / dist, sign put back afterwards
  assign div_start = (state == S_P_DXS) || (state == S_P_DYS);
  assign div_num   = (state == S_P_DXS) ? {dx_mag[11:0], 20'd0} : {dy_mag[11:0], 20'd0};

  // body ram writes: spawn, partner write-back, moving disc write-back.
  // accesses are strictly sequenced, so no same-entry overlap arises
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[ADDR_W-1:0];
    ram_wdata = '{x: xi, y: yi, vx: vxi, vy: vyi};
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_SPAWN && has_free) begin
          ram_we    = 1'b1;
          ram_waddr = free_slot;
          ram_wdata = '{x: spawn_x, y: spawn_y, vx: spawn_vel(spawn_vx),
                        vy: spawn_vel(spawn_vy)};
        end
      end
      S_T_WB: begin
        ram_we = 1'b1;
      end
      S_P_DOT4: begin
        if (!(dotv > 0)) begin
          ram_we    = 1'b1;
          ram_waddr = oth[ADDR_W-1:0];
          ram_wdata = '{x: xj, y: yj, vx: vxj, vy: vyj};
        end
      end
      S_P_CY: begin
        ram_we    = 1'b1;
        ram_waddr = oth[ADDR_W-1:0];
        ram_wdata = '{x: xj, y: yj, vx: nvxj, vy: nvyj};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      alive        <= '0;
      total        <= 4'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_TICK: begin
                cur   <= '0;
                state <= S_T_NEXT;
              end
              MODE_SPAWN: begin
                if (has_free) begin
                  alive[free_slot] <= 1'b1;
                  total            <= total + 4'd1;
                  res <= make_res(KIND_REPORT, 8'd0, 3'(free_slot), spawn_x[15:6],
                                  spawn_y[15:6], 1'b1, total + 4'd1, 1'b1);
                end else begin
                  res <= make_res(KIND_NOTHING, 8'd0, 3'd0, 10'd0, 10'd0, 1'b0,
                                  total, 1'b1);
                end
                result_valid <= 1'b1;
                ret          <= S_IDLE;
                state        <= S_OUT;
              end
              MODE_KILL: begin
                if (has_alive) begin
                  alive[high_slot] <= 1'b0;
                  total            <= total - 4'd1;
                  ram_raddr        <= high_slot;
                  rep_slot         <= high_slot;
                  rep_alive        <= 1'b0;
                  rep_count        <= total - 4'd1;
                  state            <= S_RD_WAIT;
                end else begin
                  res <= make_res(KIND_NOTHING, 8'd0, 3'd0, 10'd0, 10'd0, 1'b0,
                                  total, 1'b1);
                  result_valid <= 1'b1;
                  ret          <= S_IDLE;
                  state        <= S_OUT;
                end
              end
              MODE_CLEAR: begin
                // stores keep their contents, only the marks go
                alive <= '0;
                total <= 4'd0;
                res   <= make_res(KIND_DONE, 8'd0, 3'd0, 10'd0, 10'd0, 1'b0, 4'd0, 1'b1);
                result_valid <= 1'b1;
                ret          <= S_IDLE;
                state        <= S_OUT;
              end
              MODE_READ: begin
                if ({1'b0, body_index} >= 4'(BODY_SLOTS)) begin
                  res <= make_res(KIND_REPORT, 8'd0, body_index, 10'd0, 10'd0, 1'b0,
                                  total, 1'b1);
                  result_valid <= 1'b1;
                  ret          <= S_IDLE;
                  state        <= S_OUT;
                end else begin
                  ram_raddr <= body_index[ADDR_W-1:0];
                  rep_slot  <= body_index[ADDR_W-1:0];
                  rep_alive <= alive[body_index[ADDR_W-1:0]];
                  rep_count <= total;
                  state     <= S_RD_WAIT;
                end
              end
              default: begin
                res <= make_res(KIND_NOTHING, 8'd0, 3'd0, 10'd0, 10'd0, 1'b0,
                                total, 1'b1);
                result_valid <= 1'b1;
                ret          <= S_IDLE;
                state        <= S_OUT;
              end
            endcase
          end
        end

        // hold the result beat until the far side takes it
        S_OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= ret;
          end
        end

        S_RD_WAIT: state <= S_RD_REP;

        S_RD_REP: begin
          res <= make_res(KIND_REPORT, 8'd0, 3'(rep_slot), ram_rdata.x[15:6],
                          ram_rdata.y[15:6], rep_alive, rep_count, 1'b1);
          result_valid <= 1'b1;
          ret          <= S_IDLE;
          state        <= S_OUT;
        end

        // outer walk over discs in slot order
        S_T_NEXT: begin
          if (cur == CNT_W'(BODY_SLOTS)) begin
            res <= make_res(KIND_DONE, 8'd0, 3'd0, 10'd0, 10'd0, 1'b0, total, 1'b1);
            result_valid <= 1'b1;
            ret          <= S_IDLE;
            state        <= S_OUT;
          end else if (alive[cur[ADDR_W-1:0]]) begin
            ram_raddr <= cur[ADDR_W-1:0];
            state     <= S_T_WAIT;
          end else begin
            cur <= cur + 1'b1;
          end
        end

        S_T_WAIT: state <= S_T_LOAD;

        // move by velocity rounded to 1/64 pixel
        S_T_LOAD: begin
          xi    <= sat_pos($signed({8'd0, ram_rdata.x}) +
                           shr_round(48'($signed(ram_rdata.vx)), 4));
          yi    <= sat_pos($signed({8'd0, ram_rdata.y}) +
                           shr_round(48'($signed(ram_rdata.vy)), 4));
          vxi   <= ram_rdata.vx;
          vyi   <= ram_rdata.vy;
          wall  <= 3'd0;
          state <= S_T_WALL;
        end

        S_T_WALL: begin
          if (wall == 3'd4) begin
            oth   <= cur + 1'b1;
            state <= S_P_NEXT;
          end else begin
            wall <= wall + 3'd1;
            if (wall_hit) begin
              case (wall)
                3'd0:    begin xi <= X_CLAMP; vxi <= -abs_vel(vxi); end
                3'd1:    begin xi <= R_POS;   vxi <= abs_vel(vxi); end
                3'd2:    begin yi <= Y_CLAMP; vyi <= -abs_vel(vyi); end
                default: begin yi <= R_POS;   vyi <= abs_vel(vyi); end
              endcase
              state <= S_SPD0;
            end
          end
        end

        // impact level from the reflected speed
        S_SPD0: begin
          acc   <= 34'(mul_p);
          state <= S_SPD1;
        end
        S_SPD1: begin
          acc   <= acc + 34'(mul_p);
          state <= S_SPD2;
        end
        S_SPD2: state <= S_SPD3;
        S_SPD3: begin
          if (sq_done) begin
            res <= make_res(KIND_WALL, level_of({1'b0, sq_root[18:10]}), 3'(cur),
                            10'd0, 10'd0, 1'b0, total, 1'b0);
            result_valid <= 1'b1;
            ret          <= S_T_WALL;
            state        <= S_OUT;
          end
        end

        // inner walk over later discs
        S_P_NEXT: begin
          if (oth == CNT_W'(BODY_SLOTS)) begin
            state <= S_T_WB;
          end else if (alive[oth[ADDR_W-1:0]]) begin
            ram_raddr <= oth[ADDR_W-1:0];
            state     <= S_P_WAIT;
          end else begin
            oth <= oth + 1'b1;
          end
        end

        S_P_WAIT: state <= S_P_LOAD;

        S_P_LOAD: begin
          xj    <= ram_rdata.x;
          yj    <= ram_rdata.y;
          vxj   <= ram_rdata.vx;
          vyj   <= ram_rdata.vy;
          dx    <= $signed({1'b0, ram_rdata.x}) - $signed({1'b0, xi});
          dy    <= $signed({1'b0, ram_rdata.y}) - $signed({1'b0, yi});
          state <= S_P_D2A;
        end

        S_P_D2A: begin
          acc   <= 34'(mul_p);
          state <= S_P_D2B;
        end
        S_P_D2B: begin
          acc   <= acc + 34'(mul_p);
          state <= S_P_CHK;
        end

        // no overlap (or coincident centers): partner untouched
        S_P_CHK: begin
          if (acc != 34'd0 && acc < MIN_D2) state <= S_P_SQ;
          else state <= S_P_SKIP;
        end

        S_P_SQ: begin
          if (sq_done) begin
            d     <= sq_root;
            state <= S_P_DXS;
          end
        end

        S_P_DXS: state <= S_P_DX;
        S_P_DX: begin
          if (div_done) begin
            nx    <= dx[16] ? -$signed(div_q[19:0]) : $signed(div_q[19:0]);
            state <= S_P_DYS;
          end
        end
        S_P_DYS: state <= S_P_DY;
        S_P_DY: begin
          if (div_done) begin
            ny    <= dy[16] ? -$signed(div_q[19:0]) : $signed(div_q[19:0]);
            state <= S_P_SX;
          end
        end

        // push apart by half the overlap along the normal
        S_P_SX: begin
          pr    <= mul_p;
          state <= S_P_SX2;
        end
        S_P_SX2: begin
          sx    <= shr_round(48'(pr), 20);
          pr    <= mul_p;
          state <= S_P_SY2;
        end
        S_P_SY2: begin
          sy    <= shr_round(48'(pr), 20);
          state <= S_P_PUSH;
        end
        S_P_PUSH: begin
          xi    <= sat_pos($signed({8'd0, xi}) - sx);
          yi    <= sat_pos($signed({8'd0, yi}) - sy);
          xj    <= sat_pos($signed({8'd0, xj}) + sx);
          yj    <= sat_pos($signed({8'd0, yj}) + sy);
          state <= S_P_DOT1;
        end

        // approach speed along the normal
        S_P_DOT1: begin
          pr    <= mul_p;
          state <= S_P_DOT2;
        end
        S_P_DOT2: begin
          acc2  <= 43'(pr);
          pr    <= mul_p;
          state <= S_P_DOT3;
        end
        S_P_DOT3: begin
          dotv  <= 20'(shr_round(48'(acc2) + 48'(pr), 14));
          state <= S_P_DOT4;
        end
        S_P_DOT4: begin
          if (dotv > 0) begin
            pr    <= mul_p;
            state <= S_P_CX;
          end else begin
            state <= S_P_SKIP;
          end
        end
        S_P_CX: begin
          cx    <= shr_round(48'(pr), 14);
          pr    <= mul_p;
          state <= S_P_CY;
        end
        S_P_CY: begin
          vxi <= nvxi;
          vyi <= nvyi;
          res <= make_res(KIND_COLL, level_of(dotv[19:10]), 3'(cur), 10'd0, 10'd0,
                          1'b0, total, 1'b0);
          result_valid <= 1'b1;
          ret          <= S_P_SKIP;
          state        <= S_OUT;
        end

        S_P_SKIP: begin
          oth   <= oth + 1'b1;
          state <= S_P_NEXT;
        end

        S_T_WB: begin
          cur   <= cur + 1'b1;
          state <= S_T_NEXT;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  dcps_body_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dcps_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  dcps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (d),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire

// ----- bench/disc_table_checker.sv -----
`timescale 1ns / 1ps
module disc_table_checker
  import dcps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [2:0]  mode,
  input  logic [2:0]  body_index,
  input  logic [15:0] spawn_x,
  input  logic [15:0] spawn_y,
  input  logic [15:0] spawn_vx,
  input  logic [15:0] spawn_vy,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  impact_level,
  input  logic [2:0]  slot,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  input  logic        is_alive,
  input  logic [3:0]  body_count,
  input  logic        last,
  output int          fails,
  output int          pending
);

  localparam longint RAD = DISC_RADIUS * 64;

  longint pos_x [BODY_SLOTS];
  longint pos_y [BODY_SLOTS];
  longint vel_x [BODY_SLOTS];
  longint vel_y [BODY_SLOTS];
  logic [BODY_SLOTS-1:0] alive_mask;
  int alive_cnt;
  res_t due_results[$];
  res_t item_results[$];

  function automatic longint clamp_pos(longint v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint clamp_vel(longint v);
    return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
  endfunction

  // halves rounded away from zero
  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] level_from(longint unsigned whole);
    return (whole * 20 > 255) ? 8'd255 : 8'(whole * 20);
  endfunction

  function automatic logic [7:0] speed_level(longint vx, longint vy);
    return level_from(int_root(longint'(vx * vx + vy * vy)) >> 10);
  endfunction

  function automatic longint mag_vel(longint v);
    return clamp_vel((v < 0) ? -v : v);
  endfunction

  function automatic void note(logic [2:0] k, logic [7:0] lv, logic [2:0] s,
                               logic [9:0] x, logic [9:0] y, logic a);
    res_t r;
    r = '0;
    r.kind  = k;
    r.level = lv;
    r.slot  = s;
    r.px    = x;
    r.py    = y;
    r.alive = a;
    item_results.push_back(r);
  endfunction

  function automatic void note_body(int s, logic a);
    note(KIND_REPORT, 8'd0, 3'(s), 10'(pos_x[s] >> 6), 10'(pos_y[s] >> 6), a);
  endfunction

  function automatic void run_tick();
    longint x, y, dx, dy, d, nx, ny, ov, sx, sy, dot, cx, cy;
    longint unsigned d2;
    for (int i = 0; i < BODY_SLOTS; i++) begin
      if (!alive_mask[i]) continue;
      x = clamp_pos(pos_x[i] + round_shift(vel_x[i], 4));
      y = clamp_pos(pos_y[i] + round_shift(vel_y[i], 4));
      // walls: right, left, bottom, top
      if (x + RAD >= FIELD_WIDTH * 64) begin
        x = (FIELD_WIDTH - DISC_RADIUS) * 64;
        vel_x[i] = clamp_vel(-mag_vel(vel_x[i]));
        note(KIND_WALL, speed_level(vel_x[i], vel_y[i]), 3'(i), 0, 0, 0);
      end
      if (x - RAD <= 0) begin
        x = RAD;
        vel_x[i] = mag_vel(vel_x[i]);
        note(KIND_WALL, speed_level(vel_x[i], vel_y[i]), 3'(i), 0, 0, 0);
      end
      if (y + RAD >= FIELD_HEIGHT * 64) begin
        y = (FIELD_HEIGHT - DISC_RADIUS) * 64;
        vel_y[i] = clamp_vel(-mag_vel(vel_y[i]));
        note(KIND_WALL, speed_level(vel_x[i], vel_y[i]), 3'(i), 0, 0, 0);
      end
      if (y - RAD <= 0) begin
        y = RAD;
        vel_y[i] = mag_vel(vel_y[i]);
        note(KIND_WALL, speed_level(vel_x[i], vel_y[i]), 3'(i), 0, 0, 0);
      end
      pos_x[i] = clamp_pos(x);
      pos_y[i] = clamp_pos(y);
      // pairs with later discs
      for (int j = i + 1; j < BODY_SLOTS; j++) begin
        if (!alive_mask[j]) continue;
        dx = pos_x[j] - pos_x[i];
        dy = pos_y[j] - pos_y[i];
        d2 = dx * dx + dy * dy;
        if (d2 == 0 || d2 >= 4 * RAD * RAD) continue;
        d  = int_root(d2 * 4096);
        nx = (dx * 64 * 16384) / d;
        ny = (dy * 64 * 16384) / d;
        ov = (2 * DISC_RADIUS * 4096 - d) / 2;
        sx = round_shift(nx * ov, 20);
        sy = round_shift(ny * ov, 20);
        pos_x[i] = clamp_pos(pos_x[i] - sx);
        pos_y[i] = clamp_pos(pos_y[i] - sy);
        pos_x[j] = clamp_pos(pos_x[j] + sx);
        pos_y[j] = clamp_pos(pos_y[j] + sy);
        dot = round_shift((vel_x[i] - vel_x[j]) * nx + (vel_y[i] - vel_y[j]) * ny, 14);
        if (dot > 0) begin
          cx = round_shift(dot * nx, 14);
          cy = round_shift(dot * ny, 14);
          vel_x[i] = clamp_vel(vel_x[i] - cx);
          vel_y[i] = clamp_vel(vel_y[i] - cy);
          vel_x[j] = clamp_vel(vel_x[j] + cx);
          vel_y[j] = clamp_vel(vel_y[j] + cy);
          note(KIND_COLL, level_from(longint'(dot) >> 10), 3'(i), 0, 0, 0);
        end
      end
    end
    note(KIND_DONE, 0, 0, 0, 0, 0);
  endfunction

  function automatic longint slow_fix(logic signed [15:0] v);
    longint w;
    w = v;
    if (w > -1024 && w < 1024) w = (w >= 0) ? 1536 : -1536;
    return w;
  endfunction

  function automatic void predict_item();
    int s;
    s = -1;
    item_results.delete();
    case (mode)
      MODE_TICK: run_tick();
      MODE_SPAWN: begin
        for (int i = BODY_SLOTS - 1; i >= 0; i--) if (!alive_mask[i]) s = i;
        if (s < 0) begin
          note(KIND_NOTHING, 0, 0, 0, 0, 0);
        end else begin
          pos_x[s] = spawn_x;
          pos_y[s] = spawn_y;
          vel_x[s] = slow_fix(spawn_vx);
          vel_y[s] = slow_fix(spawn_vy);
          alive_mask[s] = 1'b1;
          alive_cnt++;
          note_body(s, 1'b1);
        end
      end
      MODE_KILL: begin
        for (int i = 0; i < BODY_SLOTS; i++) if (alive_mask[i]) s = i;
        if (s < 0) begin
          note(KIND_NOTHING, 0, 0, 0, 0, 0);
        end else begin
          alive_mask[s] = 1'b0;
          alive_cnt--;
          note_body(s, 1'b0);
        end
      end
      MODE_CLEAR: begin
        alive_mask = '0;
        alive_cnt = 0;
        note(KIND_DONE, 0, 0, 0, 0, 0);
      end
      MODE_READ: note_body(body_index, alive_mask[body_index]);
      default: note(KIND_NOTHING, 0, 0, 0, 0, 0);
    endcase
    foreach (item_results[k]) begin
      item_results[k].count = 4'(alive_cnt);
      item_results[k].last  = (k == item_results.size() - 1);
      due_results.push_back(item_results[k]);
    end
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    alive_mask = '0;
    alive_cnt = 0;
    for (int i = 0; i < BODY_SLOTS; i++) begin
      pos_x[i] = 0;
      pos_y[i] = 0;
      vel_x[i] = 0;
      vel_y[i] = 0;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (item_valid && !item_stall) predict_item();
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          if (fails < 10)
            $display("unexpected result beat: kind %0d slot %0d", kind, slot);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (kind !== want.kind || impact_level !== want.level || slot !== want.slot ||
              pixel_x !== want.px || pixel_y !== want.py || is_alive !== want.alive ||
              body_count !== want.count || last !== want.last) begin
            if (fails < 10)
              $display("mismatch exp k%0d l%0d s%0d x%0d y%0d a%0d c%0d e%0d | got k%0d l%0d s%0d x%0d y%0d a%0d c%0d e%0d",
                       want.kind, want.level, want.slot, want.px, want.py, want.alive,
                       want.count, want.last, kind, impact_level, slot, pixel_x, pixel_y,
                       is_alive, body_count, last);
            fails++;
          end
        end
      end
      pending <= due_results.size();
    end
  end

endmodule

// ----- bench/disc_collision_physics_step_unit_tb.sv -----
`timescale 1ns / 1ps
module disc_collision_physics_step_unit_tb;
  import dcps_pkg::*;

  logic clk, rst;
  logic item_valid, item_stall;
  logic [2:0] mode, body_index;
  logic [15:0] spawn_x, spawn_y;
  logic signed [15:0] spawn_vx, spawn_vy;
  logic result_valid, result_stall;
  logic [2:0] kind, slot;
  logic [7:0] impact_level;
  logic [9:0] pixel_x, pixel_y;
  logic is_alive, last;
  logic [3:0] body_count;

  int fails, pending;
  int idle_cycles;
  // no idling on either side in the closing stretch
  logic quiet;
  // shadow of the slot table, so reads only hit slots that were ever spawned
  logic [BODY_SLOTS-1:0] live_slots, seen_slots;

  disc_collision_physics_step_unit dut (
    .clk, .rst, .item_valid, .item_stall, .mode, .body_index, .spawn_x, .spawn_y,
    .spawn_vx, .spawn_vy, .result_valid, .result_stall, .kind, .impact_level, .slot,
    .pixel_x, .pixel_y, .is_alive, .body_count, .last
  );

  disc_table_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .mode, .body_index, .spawn_x, .spawn_y,
    .spawn_vx, .spawn_vy, .result_valid, .result_stall, .kind, .impact_level, .slot,
    .pixel_x, .pixel_y, .is_alive, .body_count, .last, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 40000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls in random bursts
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(logic [2:0] m, logic [2:0] idx, logic [15:0] x, logic [15:0] y,
                           logic [15:0] vx, logic [15:0] vy);
    int s;
    item_valid <= 1'b1;
    mode       <= m;
    body_index <= idx;
    spawn_x    <= x;
    spawn_y    <= y;
    spawn_vx   <= vx;
    spawn_vy   <= vy;
    do @(posedge clk); while (item_stall);
    // keep the slot shadow in step
    s = -1;
    if (m == MODE_SPAWN) begin
      for (int i = BODY_SLOTS - 1; i >= 0; i--) if (!live_slots[i]) s = i;
      if (s >= 0) begin
        live_slots[s] = 1'b1;
        seen_slots[s] = 1'b1;
      end
    end else if (m == MODE_KILL) begin
      for (int i = 0; i < BODY_SLOTS; i++) if (live_slots[i]) s = i;
      if (s >= 0) live_slots[s] = 1'b0;
    end else if (m == MODE_CLEAR) begin
      live_slots = '0;
    end
    // sender gap burst
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic spawn_near(int cx, int cy, int spread);
    logic [15:0] vx, vy;
    if ($urandom_range(0, 7) == 0) begin
      vx = 16'($urandom);
      vy = 16'($urandom);
    end else begin
      vx = 16'($signed($urandom_range(0, 8000)) - 4000);
      vy = 16'($signed($urandom_range(0, 8000)) - 4000);
    end
    send_beat(MODE_SPAWN, 3'($urandom),
              16'((cx + $signed($urandom_range(0, 2 * spread)) - spread) * 64
                  + $urandom_range(0, 63)),
              16'((cy + $signed($urandom_range(0, 2 * spread)) - spread) * 64
                  + $urandom_range(0, 63)),
              vx, vy);
  endtask

  task automatic read_any();
    int idx;
    if (seen_slots == '0) begin
      send_beat(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end else begin
      do idx = $urandom_range(0, BODY_SLOTS - 1); while (!seen_slots[idx]);
      send_beat(MODE_READ, 3'(idx), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  initial begin
    int sent, n, pick;
    logic drained;
    quiet = 1'b0;
    drained = 1'b0;
    live_slots = '0;
    seen_slots = '0;
    idle_cycles = 0;
    item_valid = 1'b0;
    mode = MODE_TICK;
    body_index = '0;
    spawn_x = '0;
    spawn_y = '0;
    spawn_vx = '0;
    spawn_vy = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table cases
    send_beat(MODE_TICK, 3'd0, 0, 0, 0, 0);
    send_beat(MODE_KILL, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(3'd5, 3'd0, 0, 0, 0, 0);
    send_beat(3'd6, 3'd0, 0, 0, 0, 0);
    send_beat(3'd7, 3'd0, 0, 0, 0, 0);
    // field extremes and slow spawn thresholds
    send_beat(MODE_SPAWN, 3'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF);
    send_beat(MODE_SPAWN, 3'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_beat(MODE_SPAWN, 3'd0, 16'd6400, 16'd6400, 16'd1023, -16'sd1023);
    send_beat(MODE_SPAWN, 3'd0, 16'd6656, 16'd6400, -16'sd1024, 16'd1024);
    // head-on pair one radius apart
    send_beat(MODE_SPAWN, 3'd0, 16'd12800, 16'd9600, 16'd2048, 16'd1100);
    send_beat(MODE_SPAWN, 3'd0, 16'd13056, 16'd9600, -16'sd2048, 16'd1100);
    send_beat(MODE_SPAWN, 3'd0, 16'd12900, 16'd9700, 16'd3000, -16'sd3000);
    send_beat(MODE_SPAWN, 3'd0, 16'd12800, 16'd9600, 16'd1500, 16'd1500);
    send_beat(MODE_SPAWN, 3'd0, 16'd1, 16'd1, 16'd1, 16'd1);   // table full
    send_beat(MODE_TICK, 3'd0, 0, 0, 0, 0);
    send_beat(MODE_TICK, 3'd0, 0, 0, 0, 0);
    for (int i = 0; i < BODY_SLOTS; i++) send_beat(MODE_READ, 3'(i), 0, 0, 0, 0);
    send_beat(MODE_KILL, 3'd0, 0, 0, 0, 0);
    send_beat(MODE_CLEAR, 3'd0, 0, 0, 0, 0);
    send_beat(MODE_READ, 3'd7, 0, 0, 0, 0);

    // random: clusters of discs then many ticks, with noise around them
    sent = 0;
    while (sent < 440) begin
      if (sent >= 400) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 2) == 0) begin
          send_beat(MODE_CLEAR, 3'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
        n = $urandom_range(2, BODY_SLOTS);
        begin
          int cx, cy;
          cx = $urandom_range(12, FIELD_WIDTH - 12);
          cy = $urandom_range(12, FIELD_HEIGHT - 12);
          for (int k = 0; k < n; k++) begin
            spawn_near(cx, cy, 8);
            sent++;
          end
        end
        n = $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
          send_beat(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
        read_any();
        sent++;
      end else if (pick < 8) begin
        send_beat(MODE_KILL, 3'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        read_any();
        sent += 2;
      end else begin
        // noise: undefined modes, spawns, ticks and reads, reads kept to written slots
        case ($urandom_range(0, 3))
          0: send_beat(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
          1: send_beat(MODE_SPAWN, 3'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
          2: send_beat(MODE_TICK, 3'($urandom), 0, 0, 0, 0);
          default: read_any();
        endcase
        sent++;
      end
      // hold off once until the table has answered everything
      if (sent >= 200 && !drained) begin
        drained = 1'b1;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
